@@ hw/rtl/p1305_pkg.sv @@
`timescale 1ns / 1ps

package p1305_pkg;

   // Item and key widths.
   localparam int WORD_W       = 64;
   localparam int BLOCK_W      = 2 * WORD_W;
   localparam int CSR_INDEX_W  = 2;

   // Radix 2^26 arithmetic. The accumulator limbs carry one spare bit, a limb plus a
   // message limb needs one more, and five times a key limb needs three more.
   localparam int LIMB_W       = 26;
   localparam int NUM_LIMBS    = 5;
   localparam int ACC_W        = LIMB_W + 1;
   localparam int SUM_W        = LIMB_W + 2;
   localparam int COEF_W       = LIMB_W + 3;
   localparam int PROD_W       = SUM_W + COEF_W;
   localparam int COL_W        = PROD_W + 4;
   localparam int FOLD_W       = COL_W - LIMB_W + 3;

   // 2^130 is congruent to 5 modulo 2^130 - 5.
   localparam int FOLD_MUL     = 5;
   localparam int CARRY_PASSES = 3;

   localparam int QUEUE_DEPTH  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_R_LOW  = 2'd0,
      CSR_R_HIGH = 2'd1,
      CSR_S_LOW  = 2'd2,
      CSR_S_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                high_bit;
      logic [WORD_W-1:0]   block_high;
      logic [WORD_W-1:0]   block_low;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] r;
      logic [BLOCK_W-1:0] s;
   } key_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_MUL,
      ENG_FOLD,
      ENG_FIN_CARRY,
      ENG_FIN_SEL,
      ENG_FIN_ADD
   } eng_state_type;

endpackage

@@ hw/rtl/p1305_front.sv @@
`timescale 1ns / 1ps

module p1305_front #(
   parameter int DEPTH = p1305_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [p1305_pkg::WORD_W-1:0]  req_block_low,
   input  logic [p1305_pkg::WORD_W-1:0]  req_block_high,
   input  logic                          req_high_bit,
   input  logic                          pop,
   output p1305_pkg::head_type           head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   p1305_pkg::item_type slot_ff [DEPTH];
   p1305_pkg::item_type word;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign push      = req_valid && req_ready;

   // Each word is tagged with its operation as it is taken in.
   always_comb begin
      word.op         = p1305_pkg::op_type'(req_op);
      word.high_bit   = req_high_bit;
      word.block_high = req_block_high;
      word.block_low  = req_block_low;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/p1305_engine.sv @@
`timescale 1ns / 1ps

module p1305_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  p1305_pkg::key_type            key,
   input  p1305_pkg::head_type           head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [p1305_pkg::WORD_W-1:0]  rsp_tag_low,
   output logic [p1305_pkg::WORD_W-1:0]  rsp_tag_high
);

   localparam int LIMB_W    = p1305_pkg::LIMB_W;
   localparam int NUM_LIMBS = p1305_pkg::NUM_LIMBS;
   localparam int ACC_W     = p1305_pkg::ACC_W;
   localparam int SUM_W     = p1305_pkg::SUM_W;
   localparam int COEF_W    = p1305_pkg::COEF_W;
   localparam int PROD_W    = p1305_pkg::PROD_W;
   localparam int COL_W     = p1305_pkg::COL_W;
   localparam int FOLD_W    = p1305_pkg::FOLD_W;
   localparam int WORD_W    = p1305_pkg::WORD_W;
   localparam int BLOCK_W   = p1305_pkg::BLOCK_W;
   localparam int EXT_W     = NUM_LIMBS * LIMB_W;
   localparam int CARRY_W   = COL_W - LIMB_W;
   localparam int IDX_W     = $clog2(NUM_LIMBS);
   localparam int STEP_W    = $clog2(NUM_LIMBS + 1);

   typedef logic [NUM_LIMBS-1:0][ACC_W-1:0] limbs_type;

   function automatic limbs_type carry_pass(input limbs_type h);
      limbs_type        o;
      logic [SUM_W-1:0] t;
      logic [SUM_W-1:0] c;
      c = '0;
      for (int i = 0; i < NUM_LIMBS; i++) begin
         t    = SUM_W'(h[i]) + c;
         c    = SUM_W'(t[SUM_W-1:LIMB_W]);
         o[i] = ACC_W'(t[LIMB_W-1:0]);
      end
      o[0] = o[0] + ACC_W'(c) * ACC_W'(p1305_pkg::FOLD_MUL);
      return o;
   endfunction

   // Adding 5 carries out of bit 130 exactly when h is at least 2^130 - 5.
   function automatic limbs_type final_select(input limbs_type h);
      limbs_type        g;
      logic [SUM_W-1:0] t;
      logic [SUM_W-1:0] c;
      c = SUM_W'(p1305_pkg::FOLD_MUL);
      for (int i = 0; i < NUM_LIMBS; i++) begin
         t    = SUM_W'(h[i]) + c;
         c    = SUM_W'(t[SUM_W-1:LIMB_W]);
         g[i] = ACC_W'(t[LIMB_W-1:0]);
      end
      return (c != '0) ? g : h;
   endfunction

   function automatic logic [BLOCK_W-1:0] pack_limbs(input limbs_type h);
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      lo = WORD_W'(h[0]) | (WORD_W'(h[1]) << LIMB_W) | (WORD_W'(h[2]) << (2 * LIMB_W));
      hi = WORD_W'(h[2] >> (WORD_W - 2 * LIMB_W))
         | (WORD_W'(h[3]) << (3 * LIMB_W - WORD_W))
         | (WORD_W'(h[4]) << (4 * LIMB_W - WORD_W));
      return {hi, lo};
   endfunction

   p1305_pkg::eng_state_type state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;

   limbs_type                            acc_ff, acc_in;
   logic [NUM_LIMBS-1:0][SUM_W-1:0]      hs_ff, hs_in;
   logic [NUM_LIMBS-1:0][PROD_W-1:0]     prod_ff, prod_in, prod_next;
   logic [NUM_LIMBS-1:0][LIMB_W-1:0]     col_ff, col_in;
   logic [CARRY_W-1:0]                   carry_ff, carry_in;
   limbs_type                            hf_ff, hf_in;
   logic [BLOCK_W-1:0]                   pack_ff, pack_in;
   logic [BLOCK_W-1:0]                   tag_ff, tag_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   logic [EXT_W-1:0]                     r_ext, m_ext;
   logic [NUM_LIMBS-1:0][LIMB_W-1:0]     r_limb, m_limb;
   logic [NUM_LIMBS-1:0][COEF_W-1:0]     x_limb, coef;
   logic [COL_W-1:0]                     col_sum;
   logic [FOLD_W-1:0]                    fold0;
   logic [IDX_W-1:0]                     col_idx;
   logic                                 rsp_free;
   logic load_absorb, load_finish, do_mul, do_fold, do_carry, do_sel, do_add;

   assign r_ext = {{(EXT_W - BLOCK_W){1'b0}}, key.r};
   assign m_ext = EXT_W'({head.item.high_bit, head.item.block_high, head.item.block_low});

   for (genvar i = 0; i < NUM_LIMBS; i++) begin : g_limb
      assign r_limb[i] = r_ext[LIMB_W*i +: LIMB_W];
      assign m_limb[i] = m_ext[LIMB_W*i +: LIMB_W];
      assign x_limb[i] = COEF_W'(r_limb[i]) * COEF_W'(p1305_pkg::FOLD_MUL);
   end

   // A finish may only start when the result register will be free by the time it lands.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         p1305_pkg::ENG_IDLE: begin
            if (head.valid) begin
               if (head.item.op == p1305_pkg::OP_ABSORB) begin
                  state_in = p1305_pkg::ENG_MUL;
                  step_in  = '0;
               end else if (rsp_free) begin
                  state_in = p1305_pkg::ENG_FIN_CARRY;
                  step_in  = '0;
               end
            end
         end
         p1305_pkg::ENG_MUL: begin
            if (step_ff == STEP_W'(NUM_LIMBS)) begin
               state_in = p1305_pkg::ENG_FOLD;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         p1305_pkg::ENG_FOLD: begin
            state_in = p1305_pkg::ENG_IDLE;
         end
         p1305_pkg::ENG_FIN_CARRY: begin
            if (step_ff == STEP_W'(p1305_pkg::CARRY_PASSES - 1)) begin
               state_in = p1305_pkg::ENG_FIN_SEL;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         p1305_pkg::ENG_FIN_SEL: begin
            state_in = p1305_pkg::ENG_FIN_ADD;
         end
         p1305_pkg::ENG_FIN_ADD: begin
            state_in = p1305_pkg::ENG_IDLE;
         end
         default: begin
            state_in = p1305_pkg::ENG_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      load_absorb = 1'b0;
      load_finish = 1'b0;
      do_mul      = 1'b0;
      do_fold     = 1'b0;
      do_carry    = 1'b0;
      do_sel      = 1'b0;
      do_add      = 1'b0;
      case (state_ff)
         p1305_pkg::ENG_IDLE: begin
            if (head.valid) begin
               if (head.item.op == p1305_pkg::OP_ABSORB) begin
                  load_absorb = 1'b1;
               end else if (rsp_free) begin
                  load_finish = 1'b1;
               end
            end
         end
         p1305_pkg::ENG_MUL:       do_mul   = 1'b1;
         p1305_pkg::ENG_FOLD:      do_fold  = 1'b1;
         p1305_pkg::ENG_FIN_CARRY: do_carry = 1'b1;
         p1305_pkg::ENG_FIN_SEL:   do_sel   = 1'b1;
         p1305_pkg::ENG_FIN_ADD:   do_add   = 1'b1;
         default: begin
            load_absorb = 1'b0;
         end
      endcase
      pop = load_absorb || load_finish;
   end

   // Column k of the product takes r[k-j] for limbs j up to k, and 5*r[k+5-j] above.
   always_comb begin
      int kk;
      kk = int'(step_ff);
      for (int j = 0; j < NUM_LIMBS; j++) begin
         if (kk >= NUM_LIMBS) begin
            coef[j] = '0;
         end else if (j <= kk) begin
            coef[j] = COEF_W'(r_limb[IDX_W'(kk - j)]);
         end else begin
            coef[j] = x_limb[IDX_W'(kk + NUM_LIMBS - j)];
         end
      end
   end

   for (genvar j = 0; j < NUM_LIMBS; j++) begin : g_mul
      assign prod_next[j] = PROD_W'(hs_ff[j]) * PROD_W'(coef[j]);
   end

   // The column sum works on the registered products of the previous step and takes the carry of the
   // previous column, so carry propagation finishes with the last column.
   always_comb begin
      col_sum = COL_W'(carry_ff);
      for (int j = 0; j < NUM_LIMBS; j++) begin
         col_sum = col_sum + COL_W'(prod_ff[j]);
      end
   end

   assign col_idx = IDX_W'(step_ff - STEP_W'(1));
   assign fold0   = FOLD_W'(col_ff[0])
                  + FOLD_W'(carry_ff) * FOLD_W'(p1305_pkg::FOLD_MUL);

   always_comb begin
      acc_in       = acc_ff;
      hs_in        = hs_ff;
      prod_in      = prod_ff;
      col_in       = col_ff;
      carry_in     = carry_ff;
      hf_in        = hf_ff;
      pack_in      = pack_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_absorb) begin
         for (int j = 0; j < NUM_LIMBS; j++) begin
            hs_in[j] = SUM_W'(acc_ff[j]) + SUM_W'(m_limb[j]);
         end
         carry_in = '0;
      end
      if (load_finish) begin
         hf_in = acc_ff;
      end
      if (do_mul) begin
         prod_in = prod_next;
         if (step_ff != '0) begin
            col_in[col_idx] = col_sum[LIMB_W-1:0];
            carry_in        = col_sum[COL_W-1:LIMB_W];
         end
      end
      if (do_fold) begin
         acc_in[0] = ACC_W'(fold0[LIMB_W-1:0]);
         acc_in[1] = ACC_W'(col_ff[1]) + ACC_W'(fold0[FOLD_W-1:LIMB_W]);
         for (int j = 2; j < NUM_LIMBS; j++) begin
            acc_in[j] = ACC_W'(col_ff[j]);
         end
      end
      if (do_carry) begin
         hf_in = carry_pass(hf_ff);
      end
      if (do_sel) begin
         pack_in = pack_limbs(final_select(hf_ff));
      end
      if (do_add) begin
         tag_in       = pack_ff + key.s;
         acc_in       = '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= p1305_pkg::ENG_IDLE;
         step_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hs_ff    <= hs_in;
      prod_ff  <= prod_in;
      col_ff   <= col_in;
      carry_ff <= carry_in;
      hf_ff    <= hf_in;
      pack_ff  <= pack_in;
      tag_ff   <= tag_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tag_low  = tag_ff[WORD_W-1:0];
   assign rsp_tag_high = tag_ff[BLOCK_W-1:WORD_W];

endmodule

@@ hw/rtl/poly1305_mac_core_unit.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Word
// req      in         req_valid/req_ready  op, block_low, block_high, high_bit
// rsp      out        rsp_valid/rsp_ready  tag_low, tag_high (finish only)
// csr      in         csr_write_en         csr_index, csr_wdata
//
// The request queue takes one word per cycle while it has room (QUEUE_DEPTH words).
// An absorb occupies the engine through its multiply and fold states: the accumulator feeds the next block, and
// the modular product is formed one column of five partial products per cycle.
// A finish occupies the engine through its carry, select and add states and waits until the result register is free.
// Reset is synchronous and clears the queue, the accumulator and the key registers.
// A stalled result holds in its register while absorbs carry on behind it.

module poly1305_mac_core_unit #(
   parameter int QUEUE_DEPTH = p1305_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [p1305_pkg::WORD_W-1:0]      req_block_low,
   input  logic [p1305_pkg::WORD_W-1:0]      req_block_high,
   input  logic                              req_high_bit,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [p1305_pkg::WORD_W-1:0]      rsp_tag_low,
   output logic [p1305_pkg::WORD_W-1:0]      rsp_tag_high,
   input  logic                              csr_write_en,
   input  logic [p1305_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [p1305_pkg::WORD_W-1:0]      csr_wdata
);

   logic [p1305_pkg::WORD_W-1:0] r_low_ff, r_high_ff, s_low_ff, s_high_ff;
   p1305_pkg::key_type           key;
   p1305_pkg::head_type          head;
   logic                         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_low_ff  <= '0;
         r_high_ff <= '0;
         s_low_ff  <= '0;
         s_high_ff <= '0;
      end else if (csr_write_en) begin
         case (p1305_pkg::csr_index_type'(csr_index))
            p1305_pkg::CSR_R_LOW:  r_low_ff  <= csr_wdata;
            p1305_pkg::CSR_R_HIGH: r_high_ff <= csr_wdata;
            p1305_pkg::CSR_S_LOW:  s_low_ff  <= csr_wdata;
            p1305_pkg::CSR_S_HIGH: s_high_ff <= csr_wdata;
            default: begin
               r_low_ff <= r_low_ff;
            end
         endcase
      end
   end

   assign key.r = {r_high_ff, r_low_ff};
   assign key.s = {s_high_ff, s_low_ff};

   p1305_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_block_low  (req_block_low),
      .req_block_high (req_block_high),
      .req_high_bit   (req_high_bit),
      .pop            (pop),
      .head           (head)
   );

   p1305_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .key          (key),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_tag_low  (rsp_tag_low),
      .rsp_tag_high (rsp_tag_high)
   );

endmodule

@@ hw/rtl/p1305_checker.sv @@
`timescale 1ns / 1ps

module p1305_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_op,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [p1305_pkg::WORD_W-1:0] rsp_tag_low,
   input logic [p1305_pkg::WORD_W-1:0] rsp_tag_high
);

   localparam int PEND_W = 8;

   // Finish words taken whose tag has not yet been delivered.
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              fin_take, rsp_take;

   assign fin_take = req_valid && req_ready && req_op;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      case ({fin_take, rsp_take})
         2'b10:   pend_in = pend_ff + PEND_W'(1);
         2'b01:   pend_in = pend_ff - PEND_W'(1);
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_tag_low) && $stable(rsp_tag_high))
      else $error("stalled result word changed");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("reset left a word pending");

   a_rsp_needs_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result word without an outstanding finish");

endmodule

bind poly1305_mac_core_unit p1305_checker u_checker (.*);
